>>> sv/mtg_pkg.sv
package mtg_pkg;

  localparam int unsigned Depth     = 624;
  localparam int unsigned AddrW     = 10;
  localparam int unsigned MixOffset = 397;

  localparam logic [31:0] TwistXor = 32'h9908_B0DF;
  localparam logic [31:0] TemperB  = 32'h9D2C_5680;
  localparam logic [31:0] TemperC  = 32'hEFC6_0000;
  localparam logic [31:0] OddStep  = 32'd527;
  localparam logic [31:0] BaseAdd  = 32'd2135;
  localparam logic [31:0] BaseMul  = 32'd74111;

  localparam logic FuncRaw    = 1'b0;
  localparam logic FuncRanged = 1'b1;

  typedef struct packed {
    logic             load_base;
    logic             we;
    logic             fill_sel;
    logic [AddrW-1:0] waddr;
    logic             rd_en;
    logic [AddrW-1:0] raddr_a;
    logic [AddrW-1:0] raddr_b;
    logic             cur_load;
    logic             req_load;
    logic             word_load;
    logic             div_step;
    logic             out_load;
  } mtg_cmd_t;

  typedef struct packed {
    logic func;
    logic span_zero;
    logic out_free;
  } mtg_stat_t;

endpackage

>>> sv/mtg_ctrl.sv
module mtg_ctrl import mtg_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      seed_we_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  mtg_stat_t stat_i,
  output mtg_cmd_t  cmd_o
);

  localparam logic [3:0] S_BASE  = 4'd0;
  localparam logic [3:0] S_FILL  = 4'd1;
  localparam logic [3:0] S_PRIME = 4'd2;
  localparam logic [3:0] S_TRD   = 4'd3;
  localparam logic [3:0] S_TWR   = 4'd4;
  localparam logic [3:0] S_IDLE  = 4'd5;
  localparam logic [3:0] S_RRD   = 4'd6;
  localparam logic [3:0] S_RWAIT = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  localparam logic [AddrW-1:0] LastIdx = AddrW'(Depth - 1);
  localparam logic [AddrW-1:0] FullIdx = AddrW'(Depth);
  localparam logic [AddrW-1:0] WrapIdx = AddrW'(Depth - MixOffset);
  localparam logic [AddrW-1:0] MixIdx  = AddrW'(MixOffset);

  logic [3:0]       state_q, state_d;
  logic [AddrW-1:0] k_q, k_d, ridx_q, ridx_d;
  logic [4:0]       dcnt_q, dcnt_d;
  logic             req_q, req_d;
  logic [AddrW-1:0] nxt, far;

  assign nxt = (k_q == LastIdx) ? '0 : k_q + AddrW'(1);
  assign far = (k_q < WrapIdx) ? k_q + MixIdx : k_q - WrapIdx;
  // a seed write takes the edge, so no request is taken with it
  assign in_stall_o = (state_q != S_IDLE) || seed_we_i;

  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    ridx_d  = ridx_q;
    dcnt_d  = dcnt_q;
    req_d   = req_q;
    cmd_o   = '0;
    cmd_o.waddr = k_q;
    unique case (state_q)
      S_BASE: begin
        cmd_o.load_base = 1'b1;
        k_d = '0;
        state_d = S_FILL;
      end
      S_FILL: begin
        cmd_o.we = 1'b1;
        cmd_o.fill_sel = 1'b1;
        k_d = k_q + AddrW'(1);
        if (k_q == LastIdx) begin
          k_d = '0;
          state_d = S_PRIME;
        end
      end
      S_PRIME: begin
        cmd_o.rd_en = 1'b1;
        state_d = S_TRD;
      end
      S_TRD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.raddr_a = nxt;
        cmd_o.raddr_b = far;
        cmd_o.cur_load = (k_q == '0);
        state_d = S_TWR;
      end
      S_TWR: begin
        cmd_o.we = 1'b1;
        k_d = k_q + AddrW'(1);
        state_d = S_TRD;
        if (k_q == LastIdx) begin
          k_d = '0;
          if (req_q) begin
            ridx_d = '0;
            state_d = S_RRD;
          end else begin
            ridx_d = FullIdx;
            state_d = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (seed_we_i) begin
          state_d = S_BASE;
        end else if (in_valid_i) begin
          cmd_o.req_load = 1'b1;
          if (ridx_q == FullIdx) begin
            req_d = 1'b1;
            state_d = S_PRIME;
          end else begin
            state_d = S_RRD;
          end
        end
      end
      S_RRD: begin
        cmd_o.rd_en = 1'b1;
        cmd_o.raddr_a = ridx_q;
        ridx_d = ridx_q + AddrW'(1);
        req_d = 1'b0;
        state_d = S_RWAIT;
      end
      S_RWAIT: begin
        cmd_o.word_load = 1'b1;
        dcnt_d = '0;
        if (stat_i.func == FuncRaw || stat_i.span_zero) state_d = S_OUT;
        else state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        dcnt_d = dcnt_q + 5'd1;
        if (dcnt_q == 5'd31) state_d = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_BASE;
    endcase
    // a seed write restarts the refill from any state
    if (seed_we_i) begin
      req_d   = 1'b0;
      state_d = S_BASE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_BASE;
      k_q     <= '0;
      ridx_q  <= FullIdx;
      dcnt_q  <= '0;
      req_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      ridx_q  <= ridx_d;
      dcnt_q  <= dcnt_d;
      req_q   <= req_d;
    end
  end

endmodule

>>> sv/mtg_dp.sv
module mtg_dp import mtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               seed_we_i,
  input  logic [31:0]        seed_i,
  input  logic               func_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  input  logic               out_stall_i,
  output logic               out_valid_o,
  output logic [31:0]        value_o,
  input  mtg_cmd_t           cmd_i,
  output mtg_stat_t          stat_o
);

  logic [31:0] mem [Depth];
  logic [31:0] seed_q, base_q, acc_odd_q, acc_even_q;
  logic [31:0] rd_a_q, rd_b_q, cur_q;
  logic        func_q;
  logic [31:0] lo_q, hi_q;
  logic [31:0] word_q, dv_q, value_q;
  logic [32:0] rem_q;
  logic        out_valid_q;
  logic [31:0] y, twist_v, wdata, span, t1, t2, t3, temper, result;
  logic [32:0] rem_sh;

  assign y       = {cur_q[31], rd_a_q[30:0]};
  assign twist_v = rd_b_q ^ (y >> 1) ^ (y[0] ? TwistXor : 32'd0);
  assign wdata   = cmd_i.fill_sel ? (cmd_i.waddr[0] ? acc_odd_q : acc_even_q) : twist_v;

  assign t1     = rd_a_q ^ (rd_a_q >> 11);
  assign t2     = t1 ^ ((t1 << 7) & TemperB);
  assign t3     = t2 ^ ((t2 << 15) & TemperC);
  assign temper = t3 ^ (t3 >> 18);

  assign span   = hi_q + 32'd1 - lo_q;
  assign rem_sh = {rem_q[31:0], dv_q[31]};

  always_comb begin
    if (func_q == FuncRaw) result = word_q;
    else if (span == '0) result = word_q + lo_q;
    else result = rem_q[31:0] + lo_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.we) mem[cmd_i.waddr] <= wdata;
    if (cmd_i.rd_en) begin
      rd_a_q <= mem[cmd_i.raddr_a];
      rd_b_q <= mem[cmd_i.raddr_b];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) seed_q <= '0;
    else if (seed_we_i) seed_q <= seed_i;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_base) begin
      base_q     <= seed_q * BaseMul + BaseAdd;
      acc_odd_q  <= seed_q;
      acc_even_q <= '0;
    end else if (cmd_i.we && cmd_i.fill_sel) begin
      acc_odd_q  <= acc_odd_q + OddStep;
      acc_even_q <= acc_even_q + base_q;
    end
    // current entry is the old next-entry word of the previous step
    if (cmd_i.cur_load || (cmd_i.we && !cmd_i.fill_sel)) cur_q <= rd_a_q;
    if (cmd_i.req_load) begin
      func_q <= func_i;
      lo_q   <= range_low_i;
      hi_q   <= range_high_i;
    end
    if (cmd_i.word_load) begin
      word_q <= temper;
      dv_q   <= temper;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      rem_q <= (rem_sh >= {1'b0, span}) ? rem_sh - {1'b0, span} : rem_sh;
      dv_q  <= dv_q << 1;
    end
    if (cmd_i.out_load) value_q <= result;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.out_load) out_valid_q <= 1'b1;
    else if (!out_stall_i) out_valid_q <= 1'b0;
  end

  assign out_valid_o      = out_valid_q;
  assign value_o          = value_q;
  assign stat_o.func      = func_q;
  assign stat_o.span_zero = (span == '0);
  assign stat_o.out_free  = !out_valid_q || !out_stall_i;

endmodule

>>> sv/mersenne_twister_generator_core.sv
// mt19937 random word generator with its own seeding rule
// input channel: in_valid_i/in_stall_o carry a request (func_i, range_low_i,
// range_high_i); func 0 returns the tempered word, func 1 returns
// (word mod span) + range_low with span = range_high + 1 - range_low
// output channel: out_valid_o/out_stall_i carry value_o, held in an output
// register so the next request can start while a result waits
// seed: seed_we_i writes seed_i and starts a refill of the 624-word table
// a raw request reads a table word and tempers it into the output register;
// a ranged request also runs the 32 steps of the bit-serial remainder unit
// the first request and every 624th one after it first twist the table,
// a read state and a write state per entry over one memory write port
// one request is in work at a time; in_stall_o is high while it runs
// and in any cycle with seed_we_i high
// reset: the table is filled from seed 0 and twisted once; in_stall_o
// stays high until both are done
// a stalled result holds until taken; a finished request waits for it
module mersenne_twister_generator_core import mtg_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               seed_we_i,
  input  logic [31:0]        seed_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               func_i,
  input  logic signed [31:0] range_low_i,
  input  logic signed [31:0] range_high_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        value_o
);

  mtg_cmd_t  cmd;
  mtg_stat_t stat;

  mtg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .seed_we_i  (seed_we_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  mtg_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .seed_we_i    (seed_we_i),
    .seed_i       (seed_i),
    .func_i       (func_i),
    .range_low_i  (range_low_i),
    .range_high_i (range_high_i),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .value_o      (value_o),
    .cmd_i        (cmd),
    .stat_o       (stat)
  );

endmodule

>>> sv/mtg_checker.sv
module mtg_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        seed_we_i,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] value_o
);

  // one request at a time
  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !seed_we_i |=> in_stall_o)
    else $error("request accepted while previous one in work");

  // reseed blocks requests
  a_busy_after_seed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seed_we_i |=> in_stall_o)
    else $error("request channel open during reseed");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(value_o))
    else $error("stalled result changed");

endmodule

bind mersenne_twister_generator_core mtg_checker u_mtg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .seed_we_i   (seed_we_i),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .value_o     (value_o)
);
